// ----- sv/brig_pkg.sv -----
// Package for the bounded random integer generator: states, constants, xorshift step.
package brig_pkg;

    localparam logic [31:0] DEFAULT_SEED = 32'd123456789;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CNT_W   = $clog2(WORD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_MUL,
        ST_CHECK,
        ST_DIV
    } state_t;

    function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] x_in);
        logic [WORD_W-1:0] x;
        x = x_in;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

endpackage

// ----- sv/bounded_random_integer_generator.sv -----
// Bounded random integer generator: xorshift32 source with multiply-and-reject bounding.
//
// Input channel s_valid/s_ready/s_range: one item requests one integer below s_range.
// Result channel m_valid/m_ready/m_value: one item per request, in order.
// Config: cfg_wr_en/cfg_wr_data reload the generator with a seed (0 selects 123456789);
// write only while the block is idle.
// In the common case an accepted item passes through draw, 32x32 multiply and
// compare before its result is valid; the sequencer then returns to idle to take
// the next item. The first time the low half of the product falls below the range,
// a bit-serial remainder unit computes the rejection threshold and the compare
// repeats; each rejected draw then repeats draw, multiply, compare.
// One item is in work at a time; s_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is accepted while the last
// result waits; if the receiver stalls, the next result holds in the compare step
// until the output register frees.
// Reset (aresetn low, synchronous) loads the generator with 123456789 and empties
// the output register.
module bounded_random_integer_generator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [brig_pkg::WORD_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brig_pkg::WORD_W-1:0]  s_range,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [brig_pkg::WORD_W-1:0]  m_value
);
    import brig_pkg::*;

    state_t                  state_reg, state_next;
    logic [WORD_W-1:0]       gen_reg, gen_next;
    logic [WORD_W-1:0]       range_reg, range_next;
    logic [2*WORD_W-1:0]     prod_reg, prod_next;
    logic [WORD_W-1:0]       thr_reg, thr_next;
    logic                    thr_valid_reg, thr_valid_next;
    logic [WORD_W-1:0]       rem_reg, rem_next;
    logic [WORD_W-1:0]       dvd_reg, dvd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]       out_value_reg, out_value_next;

    logic [WORD_W:0]         trial;
    logic [WORD_W-1:0]       rem_step;
    logic [WORD_W-1:0]       low;
    logic                    out_free;

    assign low      = prod_reg[WORD_W-1:0];
    assign out_free = !out_valid_reg || m_ready;
    assign trial    = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_step = (trial >= {1'b0, range_reg}) ? WORD_W'(trial - {1'b0, range_reg})
                                                   : trial[WORD_W-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;

    always_comb begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        range_next     = range_reg;
        prod_next      = prod_reg;
        thr_next       = thr_reg;
        thr_valid_next = thr_valid_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en) begin
                    gen_next = (cfg_wr_data != '0) ? cfg_wr_data : DEFAULT_SEED;
                end
                if (s_valid) begin
                    range_next     = s_range;
                    thr_valid_next = 1'b0;
                    state_next     = ST_DRAW;
                end
            end
            ST_DRAW: begin
                gen_next   = xorshift_step(gen_reg);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = {{WORD_W{1'b0}}, gen_reg} * {{WORD_W{1'b0}}, range_reg};
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (thr_valid_reg && (low < thr_reg)) begin
                    state_next = ST_DRAW;
                end else if (!thr_valid_reg && (low < range_reg)) begin
                    rem_next   = '0;
                    dvd_next   = WORD_W'(0) - range_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = prod_reg[2*WORD_W-1:WORD_W];
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV: begin
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                    thr_next       = rem_step;
                    thr_valid_next = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gen_reg       <= DEFAULT_SEED;
            thr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            thr_valid_reg <= thr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        range_reg     <= range_next;
        prod_reg      <= prod_next;
        thr_reg       <= thr_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
    end

endmodule
